// ===== design/assert_macros.svh =====
// assertion helpers, clock i_clk and synchronous active-low reset i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define TSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define TSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// shared types, constants and arithmetic helpers of the score accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

    localparam int CAPACITY  = 1024;
    localparam int MAX_TERMS = 8;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int MASK_W    = 8;
    localparam int COV_W     = 4;
    localparam int SCORE_W   = 32;
    localparam int DOC_W     = 32;

    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_PAIR   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        K_CONST,
        K_HIT,
        K_NEW,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [DOC_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [MASK_W-1:0]  mask;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

    function automatic logic [SCORE_W-1:0] sat_add(
        input logic [SCORE_W-1:0] a,
        input logic [SCORE_W-1:0] b
    );
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
    endfunction

    function automatic logic [MASK_W-1:0] term_bit(input logic [2:0] t);
        logic [MASK_W-1:0] b;
        b = '0;
        if (32'(t) < MAX_TERMS && 32'(t) < MASK_W) begin
            b[t] = 1'b1;
        end
        return b;
    endfunction

    function automatic logic [COV_W-1:0] coverage_of(
        input logic [MASK_W-1:0] mask,
        input logic [3:0]        active
    );
        logic [COV_W-1:0] c;
        c = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < MAX_TERMS && i < 32'(active) && mask[i]) begin
                c = c + 1'b1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/tsa_req_if.sv =====
// ----------------------------------------------------------------------------
// tsa_req_if
// request channel: posting, slot read or table clear
// ----------------------------------------------------------------------------
`default_nettype none

interface tsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] doc_id;
    logic [2:0]  first_term;
    logic [2:0]  second_term;
    logic [31:0] first_score;
    logic [31:0] second_score;
    logic [9:0]  read_slot;

    modport source (
        output valid, opcode, doc_id, first_term, second_term,
               first_score, second_score, read_slot,
        input  ready
    );
    modport sink (
        input  valid, opcode, doc_id, first_term, second_term,
               first_score, second_score, read_slot,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/tsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tsa_rsp_if
// result channel: one result per request
// ----------------------------------------------------------------------------
`default_nettype none

interface tsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [9:0]  slot_index;
    logic [31:0] entry_doc;
    logic [31:0] total_score;
    logic [7:0]  seen_mask;
    logic [3:0]  coverage;
    logic        was_new;
    logic [1:0]  status;

    modport source (
        output valid, slot_index, entry_doc, total_score, seen_mask,
               coverage, was_new, status,
        input  ready
    );
    modport sink (
        input  valid, slot_index, entry_doc, total_score, seen_mask,
               coverage, was_new, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/tsa_store.sv =====
// ----------------------------------------------------------------------------
// tsa_store
// entry memories: key, score and mask, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_store
    import tsa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    input  wire t_wr_req           i_wr,
    output t_entry                 o_rd_data
);

    logic [DOC_W-1:0]   doc_keys    [CAPACITY];
    logic [SCORE_W-1:0] score_store [CAPACITY];
    logic [MASK_W-1:0]  mask_store  [CAPACITY];
    t_entry             r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            doc_keys[i_wr.addr]    <= i_wr.data.key;
            score_store[i_wr.addr] <= i_wr.data.score;
            mask_store[i_wr.addr]  <= i_wr.data.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data.key   <= doc_keys[i_rd_addr];
            r_rd_data.score <= score_store[i_rd_addr];
            r_rd_data.mask  <= mask_store[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/term_score_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// term_score_accumulator_core
// keyed score accumulator for term-at-a-time merging
// ----------------------------------------------------------------------------
// A posting request scans the filled slots in order, one key per cycle through
// the key memory's single read port, then adds the scores and writes the entry
// back in S_FIN once the output register is free. A slot read or a clear also
// passes through S_FIN. The next request is taken while the previous result
// still waits in the output register. Reset empties the table by zeroing the
// entry count but does not clear the entry memories.
`default_nettype none
`include "assert_macros.svh"

module term_score_accumulator_core
    import tsa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    tsa_req_if.sink    i_req,
    tsa_rsp_if.source  o_rsp
);

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    t_status             r_cstat, n_cstat;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SLOT_W-1:0]   r_addr, n_addr;
    logic [3:0]          r_active_terms;
    t_op                 r_op, n_op;
    logic [DOC_W-1:0]    r_doc, n_doc;
    logic [MASK_W-1:0]   r_b1, n_b1, r_b2, n_b2;
    logic [SCORE_W-1:0]  r_s1, n_s1, r_s2, n_s2;
    logic [9:0]          r_rs, n_rs;

    logic                r_out_valid, n_out_valid;
    logic                out_load;
    logic [9:0]          r_o_slot, n_o_slot;
    logic [DOC_W-1:0]    r_o_doc, n_o_doc;
    logic [SCORE_W-1:0]  r_o_score, n_o_score;
    logic [MASK_W-1:0]   r_o_mask, n_o_mask;
    logic [COV_W-1:0]    r_o_cov, n_o_cov;
    logic                r_o_new, n_o_new;
    t_status             r_o_stat, n_o_stat;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    t_wr_req             wr;
    t_entry              rd_data;

    logic [SCORE_W-1:0]  base_score, sc1, sc2;
    logic [MASK_W-1:0]   base_mask, new_mask;
    logic                add1, add2;

    tsa_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    // score update from the entry on the read port, or from zero for a new doc
    always_comb begin
        base_score = (r_kind == K_HIT) ? rd_data.score : '0;
        base_mask  = (r_kind == K_HIT) ? rd_data.mask : '0;
        add1       = (r_op == OP_SINGLE) || ((base_mask & r_b1) == '0);
        add2       = (r_op == OP_PAIR) && ((base_mask & r_b2) == '0);
        sc1        = add1 ? sat_add(base_score, r_s1) : base_score;
        sc2        = add2 ? sat_add(sc1, r_s2) : sc1;
        new_mask   = base_mask | r_b1 | ((r_op == OP_PAIR) ? r_b2 : '0);
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_cstat     = r_cstat;
        n_count     = r_count;
        n_addr      = r_addr;
        n_op        = r_op;
        n_doc       = r_doc;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_rs        = r_rs;
        rd_en       = 1'b0;
        rd_addr     = r_addr + 1'b1;
        wr          = '0;
        out_load    = 1'b0;
        n_o_slot    = r_o_slot;
        n_o_doc     = r_o_doc;
        n_o_score   = r_o_score;
        n_o_mask    = r_o_mask;
        n_o_cov     = r_o_cov;
        n_o_new     = r_o_new;
        n_o_stat    = r_o_stat;
        i_req.ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op  = t_op'(i_req.opcode);
                    n_doc = i_req.doc_id;
                    n_b1  = term_bit(i_req.first_term);
                    n_b2  = term_bit(i_req.second_term);
                    n_s1  = i_req.first_score;
                    n_s2  = i_req.second_score;
                    n_rs  = i_req.read_slot;
                    case (t_op'(i_req.opcode))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_kind  = K_CONST;
                            n_cstat = ST_OK;
                            n_state = S_FIN;
                        end
                        OP_READ: begin
                            if (32'(i_req.read_slot) >= 32'(r_count)
                                    || 32'(i_req.read_slot) >= CAPACITY) begin
                                n_kind  = K_CONST;
                                n_cstat = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = SLOT_W'(i_req.read_slot);
                                n_kind  = K_READ;
                            end
                            n_state = S_FIN;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_kind  = K_NEW;
                                n_state = S_FIN;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_addr  = '0;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_data.key == r_doc) begin
                    n_kind  = K_HIT;
                    n_state = S_FIN;
                end else if (CNT_W'(r_addr) + 1'b1 == r_count) begin
                    if (32'(r_count) == CAPACITY) begin
                        n_kind  = K_CONST;
                        n_cstat = ST_FULL;
                    end else begin
                        n_kind = K_NEW;
                    end
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    n_o_new  = 1'b0;
                    n_o_stat = ST_OK;
                    case (r_kind)
                        K_HIT, K_NEW: begin
                            wr.en         = 1'b1;
                            wr.addr       = (r_kind == K_HIT) ? r_addr
                                                              : SLOT_W'(r_count);
                            wr.data.key   = r_doc;
                            wr.data.score = sc2;
                            wr.data.mask  = new_mask;
                            n_o_slot      = 10'(wr.addr);
                            n_o_doc       = r_doc;
                            n_o_score     = sc2;
                            n_o_mask      = new_mask;
                            n_o_cov       = coverage_of(new_mask, r_active_terms);
                            if (r_kind == K_NEW) begin
                                n_o_new = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        K_READ: begin
                            n_o_slot  = r_rs;
                            n_o_doc   = rd_data.key;
                            n_o_score = rd_data.score;
                            n_o_mask  = rd_data.mask;
                            n_o_cov   = coverage_of(rd_data.mask, r_active_terms);
                        end
                        default: begin
                            n_o_slot  = (r_cstat == ST_EMPTY) ? r_rs : '0;
                            n_o_doc   = (r_cstat == ST_FULL) ? r_doc : '0;
                            n_o_score = '0;
                            n_o_mask  = '0;
                            n_o_cov   = '0;
                            n_o_stat  = r_cstat;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_active_terms <= 4'd4;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_active_terms <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_cstat   <= n_cstat;
        r_addr    <= n_addr;
        r_op      <= n_op;
        r_doc     <= n_doc;
        r_b1      <= n_b1;
        r_b2      <= n_b2;
        r_s1      <= n_s1;
        r_s2      <= n_s2;
        r_rs      <= n_rs;
        r_o_slot  <= n_o_slot;
        r_o_doc   <= n_o_doc;
        r_o_score <= n_o_score;
        r_o_mask  <= n_o_mask;
        r_o_cov   <= n_o_cov;
        r_o_new   <= n_o_new;
        r_o_stat  <= n_o_stat;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.slot_index  = r_o_slot;
    assign o_rsp.entry_doc   = r_o_doc;
    assign o_rsp.total_score = r_o_score;
    assign o_rsp.seen_mask   = r_o_mask;
    assign o_rsp.coverage    = r_o_cov;
    assign o_rsp.was_new     = r_o_new;
    assign o_rsp.status      = r_o_stat;

    `TSA_ASSERT(a_count_bound, 32'(r_count) <= CAPACITY, "entry count above capacity")
    `TSA_ASSERT_IMP(a_scan_in_range, r_state == S_SCAN, CNT_W'(r_addr) < r_count, "scan past fill")
    `TSA_ASSERT_IMP(a_write_on_fin, wr.en, r_state == S_FIN && out_load, "stray memory write")
    `TSA_ASSERT_NXT(a_new_bumps, wr.en && r_kind == K_NEW, r_count == $past(r_count) + 1'b1, "count not bumped")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// testbench of term_score_accumulator_core
// ----------------------------------------------------------------------------
// Drives single and pair postings, slot reads and table clears through the
// request channel. Every accepted request is run through a local model of the
// table, and the result it gives is queued. Each result taken from the block
// is checked field by field against the oldest queued one. Covers the table
// filling to capacity, saturating sums, repeated terms, reads past the fill
// level and a sweep of active term counts. Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import tsa_pkg::*;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam real HALF_PERIOD  = 5.0;

    typedef struct {
        t_op         op;
        logic [31:0] doc;
        logic [2:0]  t1;
        logic [2:0]  t2;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [9:0]  rs;
    } t_request;

    typedef struct packed {
        logic [9:0]  slot;
        logic [31:0] doc;
        logic [31:0] score;
        logic [7:0]  mask;
        logic [3:0]  cov;
        logic        is_new;
        t_status     st;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [3:0] i_cfg_wdata;

    tsa_req_if req_bus ();
    tsa_rsp_if rsp_bus ();

    term_score_accumulator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus.sink),
        .o_rsp       (rsp_bus.source)
    );

    // local copy of the table
    logic [31:0] key_mem [CAPACITY];
    logic [31:0] score_mem [CAPACITY];
    logic [7:0]  mask_mem [CAPACITY];
    int unsigned fill_level;
    logic [3:0]  active_cnt;

    t_result     pending_results [$];
    int unsigned error_cnt;
    int unsigned cycle_cnt;
    int unsigned n_postings, n_dropped, n_reads, n_clears, n_cfg;
    bit          no_idle;
    bit          rsp_no_stall;

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [3:0] cover_count(input logic [7:0] mask);
        int lim;
        logic [3:0] c;
        lim = (active_cnt > MAX_TERMS) ? MAX_TERMS : active_cnt;
        c = '0;
        for (int i = 0; i < lim; i++) begin
            if (mask[i]) c = c + 1'b1;
        end
        return c;
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_result apply_request(input t_request r);
        t_result res;
        int hit;
        logic [7:0] b1, b2, old;
        logic [31:0] sc;
        res = '0;
        res.st = ST_OK;
        b1 = 8'd1 << r.t1;
        b2 = 8'd1 << r.t2;
        if (r.op == OP_CLEAR) begin
            fill_level = 0;
            n_clears++;
            return res;
        end
        if (r.op == OP_READ) begin
            n_reads++;
            res.slot = r.rs;
            if (r.rs >= fill_level) begin
                res.st = ST_EMPTY;
                return res;
            end
            res.doc   = key_mem[r.rs];
            res.score = score_mem[r.rs];
            res.mask  = mask_mem[r.rs];
            res.cov   = cover_count(mask_mem[r.rs]);
            return res;
        end
        n_postings++;
        hit = -1;
        for (int i = 0; i < fill_level; i++) begin
            if (key_mem[i] == r.doc) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) begin
            if (fill_level >= CAPACITY) begin
                n_dropped++;
                res.doc = r.doc;
                res.st  = ST_FULL;
                return res;
            end
            hit = fill_level;
            key_mem[hit]   = r.doc;
            score_mem[hit] = (r.op == OP_SINGLE) ? r.s1 : add_sat(r.s1, r.s2);
            mask_mem[hit]  = (r.op == OP_SINGLE) ? b1 : (b1 | b2);
            fill_level++;
            res.is_new = 1'b1;
        end else if (r.op == OP_SINGLE) begin
            score_mem[hit] = add_sat(score_mem[hit], r.s1);
            mask_mem[hit]  = mask_mem[hit] | b1;
        end else begin
            old = mask_mem[hit];
            sc  = score_mem[hit];
            if ((old & b1) == 0) sc = add_sat(sc, r.s1);
            if ((old & b2) == 0) sc = add_sat(sc, r.s2);
            score_mem[hit] = sc;
            mask_mem[hit]  = old | b1 | b2;
        end
        res.slot  = hit[9:0];
        res.doc   = r.doc;
        res.score = score_mem[hit];
        res.mask  = mask_mem[hit];
        res.cov   = cover_count(mask_mem[hit]);
        return res;
    endfunction

    function automatic bit roll_idle();
        return ($urandom_range(99) < 29);
    endfunction

    task automatic send_request(input t_request r);
        @(negedge i_clk);
        while (!no_idle && roll_idle()) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.opcode       <= r.op;
        req_bus.doc_id       <= r.doc;
        req_bus.first_term   <= r.t1;
        req_bus.second_term  <= r.t2;
        req_bus.first_score  <= r.s1;
        req_bus.second_score <= r.s2;
        req_bus.read_slot    <= r.rs;
        do @(posedge i_clk); while (!req_bus.ready);
        pending_results = {pending_results, apply_request(r)};
    endtask

    task automatic post(input t_op op, input logic [31:0] doc, input logic [2:0] t1,
                        input logic [2:0] t2, input logic [31:0] s1, input logic [31:0] s2);
        t_request r;
        r = '{op, doc, t1, t2, s1, s2, 10'($urandom)};
        send_request(r);
    endtask

    task automatic read_at(input logic [9:0] slot);
        t_request r;
        r = '{OP_READ, $urandom, 3'($urandom), 3'($urandom), $urandom, $urandom, slot};
        send_request(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_active(input logic [3:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        active_cnt = value;
        n_cfg++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result slot %0d doc %h", $time,
                         rsp_bus.slot_index, rsp_bus.entry_doc);
                error_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                if (rsp_bus.slot_index !== exp_r.slot) begin
                    $display("%0t slot_index exp %0d got %0d", $time, exp_r.slot,
                             rsp_bus.slot_index);
                    error_cnt++;
                end
                if (rsp_bus.entry_doc !== exp_r.doc) begin
                    $display("%0t entry_doc exp %h got %h", $time, exp_r.doc,
                             rsp_bus.entry_doc);
                    error_cnt++;
                end
                if (rsp_bus.total_score !== exp_r.score) begin
                    $display("%0t total_score exp %h got %h", $time, exp_r.score,
                             rsp_bus.total_score);
                    error_cnt++;
                end
                if (rsp_bus.seen_mask !== exp_r.mask) begin
                    $display("%0t seen_mask exp %b got %b", $time, exp_r.mask,
                             rsp_bus.seen_mask);
                    error_cnt++;
                end
                if (rsp_bus.coverage !== exp_r.cov) begin
                    $display("%0t coverage exp %0d got %0d", $time, exp_r.cov,
                             rsp_bus.coverage);
                    error_cnt++;
                end
                if (rsp_bus.was_new !== exp_r.is_new) begin
                    $display("%0t was_new exp %b got %b", $time, exp_r.is_new,
                             rsp_bus.was_new);
                    error_cnt++;
                end
                if (rsp_bus.status !== exp_r.st) begin
                    $display("%0t status exp %0d got %0d", $time, exp_r.st,
                             rsp_bus.status);
                    error_cnt++;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        rsp_bus.ready <= rsp_no_stall ? 1'b1 : !roll_idle();
    end

    task automatic test_directed();
        read_at(10'd0);
        post(OP_SINGLE, 32'h0000_0000, 3'd0, 3'd7, 32'h0000_0000, 32'hFFFF_FFFF);
        post(OP_SINGLE, 32'hFFFF_FFFF, 3'd7, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000);
        post(OP_SINGLE, 32'hFFFF_FFFF, 3'd3, 3'd0, 32'h0000_0001, 32'h0000_0000);
        post(OP_PAIR, 32'hFFFF_FFFF, 3'd7, 3'd1, 32'h0001_0000, 32'h0000_8000);
        post(OP_PAIR, 32'h1234_5678, 3'd2, 3'd2, 32'h8000_0000, 32'h8000_0000);
        post(OP_PAIR, 32'h1234_5678, 3'd2, 3'd5, 32'h0000_1000, 32'h0002_0000);
        post(OP_SINGLE, 32'h1234_5678, 3'd2, 3'd0, 32'h0000_0100, 32'h0);
        post(OP_PAIR, 32'hA5A5_5A5A, 3'd0, 3'd6, 32'hFFFF_0000, 32'h0001_0000);
        post(OP_PAIR, 32'h0000_0000, 3'd1, 3'd0, 32'h0003_0000, 32'h0004_0000);
        read_at(10'd0);
        read_at(10'd3);
        read_at(10'd4);
        read_at(10'd1023);
        post(OP_CLEAR, 32'h0, 3'd0, 3'd0, 32'h0, 32'h0);
        read_at(10'd0);
        post(OP_SINGLE, 32'h5A5A_A5A5, 3'd4, 3'd0, 32'h0000_FFFF, 32'h0);
        read_at(10'd0);
        read_at(10'd1);
        post(OP_CLEAR, 32'h0, 3'd0, 3'd0, 32'h0, 32'h0);
    endtask

    task automatic test_full_table();
        logic [31:0] base;
        base = $urandom;
        no_idle = 1'b1;
        rsp_no_stall = 1'b1;
        post(OP_CLEAR, 32'h0, 3'd0, 3'd0, 32'h0, 32'h0);
        for (int i = 0; i < CAPACITY; i++) begin
            post((i % 2) ? OP_PAIR : OP_SINGLE, base ^ (i * 32'h9E37_79B9),
                 3'($urandom), 3'($urandom), $urandom_range(32'hFFFF), $urandom_range(32'hFFFF));
        end
        no_idle = 1'b0;
        rsp_no_stall = 1'b0;
        post(OP_SINGLE, ~base, 3'd1, 3'd2, 32'h1, 32'h2);
        post(OP_PAIR, base ^ 32'h8000_0001, 3'd3, 3'd4, 32'h5, 32'h6);
        post(OP_SINGLE, base ^ (1023 * 32'h9E37_79B9), 3'd6, 3'd0, 32'hFFFF_FFFF, 32'h0);
        post(OP_PAIR, base, 3'd0, 3'd1, 32'h0001_0000, 32'h0001_0000);
        read_at(10'd1023);
        read_at(10'd0);
        read_at(10'd512);
        post(OP_CLEAR, 32'h0, 3'd0, 3'd0, 32'h0, 32'h0);
        read_at(10'd1023);
    endtask

    function automatic logic [31:0] pick_score();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0003_FFFF);
            1: return 32'hFFFF_FFFF - $urandom_range(32'h0001_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random(input int count, input bit with_pause);
        t_request r;
        logic [31:0] base;
        int roll;
        base = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) no_idle = 1'b1;
            if (n == count / 3 + 60) no_idle = 1'b0;
            if (with_pause && n == count / 2) drain();
            roll = $urandom_range(99);
            r.op = (roll < 45) ? OP_SINGLE : (roll < 80) ? OP_PAIR :
                   (roll < 96) ? OP_READ : OP_CLEAR;
            r.doc = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(23);
            r.t1 = 3'($urandom);
            r.t2 = ($urandom_range(5) == 0) ? r.t1 : 3'($urandom);
            r.s1 = pick_score();
            r.s2 = pick_score();
            r.rs = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(fill_level + 2));
            send_request(r);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.opcode = OP_SINGLE;
        req_bus.doc_id = '0;
        req_bus.first_term = '0;
        req_bus.second_term = '0;
        req_bus.first_score = '0;
        req_bus.second_score = '0;
        req_bus.read_slot = '0;
        fill_level = 0;
        active_cnt = 4'd4;
        no_idle = 1'b0;
        rsp_no_stall = 1'b0;
        n_postings = 0; n_dropped = 0; n_reads = 0; n_clears = 0; n_cfg = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_active(4'd8);
        test_directed();
        set_active(4'd0);
        test_random(150, 1'b0);
        set_active(4'd15);
        test_full_table();
        set_active(4'd1);
        test_random(250, 1'b1);
        set_active(4'd5);
        test_random(250, 1'b0);
        set_active(4'd8);
        test_random(200, 1'b0);

        drain();
        $display("%0d postings (%0d dropped on a full table), %0d slot reads, %0d clears",
                 n_postings, n_dropped, n_reads, n_clears);
        $display("%0d active term settings, including 0, 1, 8 and 15", n_cfg + 1);
        if (error_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
